### hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the sprite vertex block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Plain condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  `ASSERT_PROP(lbl, clk, rst, (cond), msg)

`endif

### hw/rtl/sqv_pkg.sv
// Package: constants and types of the sprite quad vertex generator.
`timescale 1ns / 1ps
package sqv_pkg;
  // Corner index of the final vertex of a sprite.
  localparam logic [1:0] CORNER_LAST = 2'd3;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  // Sine polynomial coefficients.
  localparam logic [16:0] SIN_C1 = 17'd102944;
  localparam logic [15:0] SIN_C3 = 16'd42048;
  localparam logic [12:0] SIN_C5 = 13'd4640;
  localparam logic [16:0] TRIG_ONE = 17'd65536;
  // Texture coordinate: 23 magnitude bits, saturation value.
  localparam int TEX_QBITS = 23;
  localparam logic [23:0] TEX_MAX = 24'd8388607;
  // Pipeline depths.
  localparam int TRIG_LAT = 5;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS = 6;
  localparam int PIPE_LAT = TRIG_LAT + 2;

  // Sideband that travels with each vertex.
  typedef struct packed {
    logic        valid;
    logic [1:0]  corner;
    logic        last;
    logic [15:0] depth;
    logic [31:0] color;
  } side_t;
endpackage

### hw/rtl/sqv_trig.sv
// Pipelined sine and cosine of a binary angle, quarter-wave polynomial.
`timescale 1ns / 1ps
module sqv_trig (
  input  logic               clk,
  input  logic [15:0]        angle,
  output logic signed [17:0] sn,
  output logic signed [17:0] cs
);
  import sqv_pkg::*;

  logic [15:0] arg [2];
  logic [14:0] rr [2];
  logic [16:0] z [2];
  logic [33:0] zz [2];
  logic [33:0] prod2 [2];
  logic [33:0] prod3 [2];
  logic signed [35:0] sum [2];
  logic signed [19:0] shf [2];
  logic [16:0] mag [2];

  logic [16:0] p1_z [2], p1_z2 [2];
  logic [16:0] p2_z [2], p2_z2 [2], p2_z3 [2];
  logic [16:0] p3_z5 [2], p3_z3 [2];
  logic [33:0] p3_t1 [2];
  logic signed [34:0] p4_t13 [2];
  logic [28:0] p4_t5 [2];
  logic [3:0] neg [2];
  logic signed [17:0] res [2];

  // lane 0 is sine, lane 1 is cosine (sine shifted a quarter turn)
  assign arg[0] = angle;
  assign arg[1] = angle + QUARTER_TURN;

  // quadrant folding, squared term, stage products, final sum and clamp
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rr[l] = arg[l][14] ? 15'(QUARTER_TURN[14:0] - {1'b0, arg[l][13:0]})
                         : {1'b0, arg[l][13:0]};
      z[l] = {rr[l], 2'b00};
      zz[l] = z[l] * z[l];
      prod2[l] = p1_z2[l] * p1_z[l];
      prod3[l] = p2_z3[l] * p2_z2[l];
      sum[l] = 36'(p4_t13[l]) + $signed({7'b0, p4_t5[l]});
      shf[l] = sum[l][35:16];
      if (shf[l] < 0) begin
        mag[l] = '0;
      end else if (shf[l] > $signed({3'b0, TRIG_ONE})) begin
        mag[l] = TRIG_ONE;
      end else begin
        mag[l] = shf[l][16:0];
      end
    end
  end

  // five register stages: z^2, z^3, z^5 and terms, last term, sum and clamp
  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      p1_z[l] <= z[l];
      p1_z2[l] <= zz[l][32:16];
      neg[l] <= {neg[l][2:0], arg[l][15]};
      p2_z[l] <= p1_z[l];
      p2_z2[l] <= p1_z2[l];
      p2_z3[l] <= prod2[l][32:16];
      p3_z5[l] <= prod3[l][32:16];
      p3_z3[l] <= p2_z3[l];
      p3_t1[l] <= SIN_C1 * p2_z[l];
      p4_t13[l] <= $signed({1'b0, p3_t1[l]}) - $signed({3'b0, 32'(SIN_C3 * p3_z3[l])});
      p4_t5[l] <= SIN_C5 * p3_z5[l];
      res[l] <= neg[l][3] ? -$signed({1'b0, mag[l]}) : $signed({1'b0, mag[l]});
    end
  end

  assign sn = res[0];
  assign cs = res[1];
endmodule

### hw/rtl/sqv_rot.sv
// Corner offset, rotation by sine/cosine, rounding and translation.
`timescale 1ns / 1ps
module sqv_rot (
  input  logic               clk,
  input  logic [1:0]         corner,
  input  logic [31:0]        width,
  input  logic [31:0]        height,
  input  logic [31:0]        org_x,
  input  logic [31:0]        org_y,
  input  logic [31:0]        dest_x,
  input  logic [31:0]        dest_y,
  input  logic signed [17:0] sn,
  input  logic signed [17:0] cs,
  output logic [31:0]        pos_x,
  output logic [31:0]        pos_y
);
  import sqv_pkg::*;

  logic signed [33:0] offx, offy;
  logic signed [33:0] offx_d [TRIG_LAT], offy_d [TRIG_LAT];
  logic [31:0] dx_d [TRIG_LAT+1], dy_d [TRIG_LAT+1];
  logic signed [51:0] pxc, pys, pxs, pyc;
  logic signed [52:0] rx, ry;

  // offset = corner * size - origin, exact
  assign offx = $signed({2'b00, corner[0] ? width : 32'd0}) -
                $signed({{2{org_x[31]}}, org_x});
  assign offy = $signed({2'b00, corner[1] ? height : 32'd0}) -
                $signed({{2{org_y[31]}}, org_y});

  // round once at the summed product, then wrap onto dest
  assign rx = 53'(pxc) - 53'(pys) + 53'sd32768;
  assign ry = 53'(pxs) + 53'(pyc) + 53'sd32768;

  always_ff @(posedge clk) begin
    offx_d[0] <= offx;
    offy_d[0] <= offy;
    dx_d[0] <= dest_x;
    dy_d[0] <= dest_y;
    for (int k = 1; k < TRIG_LAT; k++) begin
      offx_d[k] <= offx_d[k-1];
      offy_d[k] <= offy_d[k-1];
    end
    for (int k = 1; k <= TRIG_LAT; k++) begin
      dx_d[k] <= dx_d[k-1];
      dy_d[k] <= dy_d[k-1];
    end
    // products, aligned with the trig result
    pxc <= offx_d[TRIG_LAT-1] * cs;
    pys <= offy_d[TRIG_LAT-1] * sn;
    pxs <= offx_d[TRIG_LAT-1] * sn;
    pyc <= offy_d[TRIG_LAT-1] * cs;
    pos_x <= dx_d[TRIG_LAT] + rx[47:16];
    pos_y <= dy_d[TRIG_LAT] + ry[47:16];
  end
endmodule

### hw/rtl/sqv_div.sv
// Pipelined restoring divider for one texture coordinate, with saturation.
`timescale 1ns / 1ps
module sqv_div #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic [15:0] start_tx,
  input  logic [15:0] len_tx,
  input  logic        sel,
  input  logic [15:0] tsize,
  output logic [23:0] tex
);
  import sqv_pkg::*;

  localparam int DW = 17 + COORD_FRAC_BITS;

  logic [16:0] num;
  logic [DW-1:0] dividend;

  logic [16:0] rem_q [DIV_STAGES];
  logic [DW-1:0] n_q [DIV_STAGES];
  logic [TEX_QBITS-1:0] quo_q [DIV_STAGES];
  logic [15:0] d_q [DIV_STAGES];
  logic zero_q [DIV_STAGES];
  logic sat_q [DIV_STAGES];

  assign num = {1'b0, start_tx} + (sel ? {1'b0, len_tx} : 17'd0);
  assign dividend = DW'(num) << COORD_FRAC_BITS;

  // DIV_STEPS quotient bits per stage, most significant first
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [16:0] rem_in;
    logic [DW-1:0] n_in;
    logic [TEX_QBITS-1:0] quo_in;
    logic [15:0] d_in;
    logic zero_in, sat_in;
    logic [16:0] rem_w;
    logic [TEX_QBITS-1:0] quo_w;

    if (s == 0) begin : g_first
      assign rem_in = 17'(dividend >> TEX_QBITS);
      assign n_in = dividend;
      assign quo_in = '0;
      assign d_in = tsize;
      assign zero_in = (tsize == 16'd0);
      assign sat_in = {15'b0, num} >= (32'(tsize) << (TEX_QBITS - COORD_FRAC_BITS));
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign n_in = n_q[s-1];
      assign quo_in = quo_q[s-1];
      assign d_in = d_q[s-1];
      assign zero_in = zero_q[s-1];
      assign sat_in = sat_q[s-1];
    end

    always_comb begin
      rem_w = rem_in;
      quo_w = quo_in;
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (TEX_QBITS - 1 - s * DIV_STEPS - j >= 0) begin
          rem_w = {rem_w[15:0], n_in[TEX_QBITS - 1 - s * DIV_STEPS - j]};
          if (rem_w >= {1'b0, d_in}) begin
            rem_w = rem_w - {1'b0, d_in};
            quo_w[TEX_QBITS - 1 - s * DIV_STEPS - j] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_q[s] <= rem_w;
      n_q[s] <= n_in;
      quo_q[s] <= quo_w;
      d_q[s] <= d_in;
      zero_q[s] <= zero_in;
      sat_q[s] <= sat_in;
    end
  end

  // zero texture size gives 0, a quotient past range saturates
  assign tex = zero_q[DIV_STAGES-1] ? 24'd0 :
               sat_q[DIV_STAGES-1] ? TEX_MAX : {1'b0, quo_q[DIV_STAGES-1]};
endmodule

### hw/rtl/sprite_quad_vertex_generation.sv
// Top level: sprite sequencer, corner pipeline and vertex output.
//
//  channel  | handshake         | payload
//  ---------+-------------------+-------------------------------------------
//  sprite   | start / busy      | dest_x dest_y dest_size source_rect
//           |                   | texture_size origin angle depth color mirror
//  vertex   | strobe            | corner pos_x pos_y vertex_depth tex_u tex_v
//           |                   | vertex_color last
//
// A sprite is taken when start is high and busy low; it issues one corner a
// cycle on the single vertex output; the next sprite can be taken in the
// cycle its last corner issues, so corners of back-to-back sprites do not gap.
// Each corner runs a 7-stage pipeline (5 trig stages, 2 rotation stages; the
// divider takes 4). The receiver cannot stall: every result is a one-cycle
// strobe. Synchronous reset drops all sprites in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sprite_quad_vertex_generation #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] dest_x,
  input  logic signed [31:0] dest_y,
  input  logic [63:0]        dest_size,
  input  logic [63:0]        source_rect,
  input  logic [31:0]        texture_size,
  input  logic [63:0]        origin,
  input  logic [15:0]        angle,
  input  logic [15:0]        depth,
  input  logic [31:0]        color,
  input  logic [1:0]         mirror,
  output logic               strobe,
  output logic [1:0]         corner,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [15:0]        vertex_depth,
  output logic signed [23:0] tex_u,
  output logic signed [23:0] tex_v,
  output logic [31:0]        vertex_color,
  output logic               last
);
  import sqv_pkg::*;

  logic active;
  logic [1:0] cnt;
  logic [31:0] s_dx, s_dy;
  logic [63:0] s_size, s_src, s_org;
  logic [31:0] s_tsz, s_col;
  logic [15:0] s_ang, s_dep;
  logic [1:0] s_mir;
  logic accept;
  logic [1:0] msel;
  logic signed [17:0] sn, cs;
  logic [31:0] px, py;
  logic [23:0] u_div, v_div;
  logic [23:0] u_d [PIPE_LAT-DIV_STAGES], v_d [PIPE_LAT-DIV_STAGES];
  side_t side_in;
  side_t side_q [PIPE_LAT];

  // sequencer: hold the sprite, step through its corners
  assign busy = active && (cnt != CORNER_LAST);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt <= 2'd0;
    end else if (accept) begin
      active <= 1'b1;
      cnt <= 2'd0;
    end else if (active) begin
      active <= (cnt != CORNER_LAST);
      cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_dx <= dest_x;
      s_dy <= dest_y;
      s_size <= dest_size;
      s_src <= source_rect;
      s_tsz <= texture_size;
      s_org <= origin;
      s_ang <= angle;
      s_dep <= depth;
      s_col <= color;
      s_mir <= mirror;
    end
  end

  assign msel = cnt ^ s_mir;

  sqv_trig u_trig (
    .clk   (clk),
    .angle (s_ang),
    .sn    (sn),
    .cs    (cs)
  );

  sqv_rot u_rot (
    .clk    (clk),
    .corner (cnt),
    .width  (s_size[31:0]),
    .height (s_size[63:32]),
    .org_x  (s_org[31:0]),
    .org_y  (s_org[63:32]),
    .dest_x (s_dx),
    .dest_y (s_dy),
    .sn     (sn),
    .cs     (cs),
    .pos_x  (px),
    .pos_y  (py)
  );

  sqv_div #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_div_u (
    .clk      (clk),
    .start_tx (s_src[15:0]),
    .len_tx   (s_src[47:32]),
    .sel      (msel[0]),
    .tsize    (s_tsz[15:0]),
    .tex      (u_div)
  );

  sqv_div #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_div_v (
    .clk      (clk),
    .start_tx (s_src[31:16]),
    .len_tx   (s_src[63:48]),
    .sel      (msel[1]),
    .tsize    (s_tsz[31:16]),
    .tex      (v_div)
  );

  // sideband delay line, valid cleared on reset
  assign side_in = '{valid: active, corner: cnt, last: (cnt == CORNER_LAST),
                     depth: s_dep, color: s_col};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PIPE_LAT; k++) begin
        side_q[k] <= '0;
      end
    end else begin
      side_q[0] <= side_in;
      for (int k = 1; k < PIPE_LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // align texture coordinates with the position pipeline
  always_ff @(posedge clk) begin
    u_d[0] <= u_div;
    v_d[0] <= v_div;
    for (int k = 1; k < PIPE_LAT - DIV_STAGES; k++) begin
      u_d[k] <= u_d[k-1];
      v_d[k] <= v_d[k-1];
    end
  end

  assign strobe = side_q[PIPE_LAT-1].valid;
  assign corner = side_q[PIPE_LAT-1].corner;
  assign last = side_q[PIPE_LAT-1].last;
  assign vertex_depth = side_q[PIPE_LAT-1].depth;
  assign vertex_color = side_q[PIPE_LAT-1].color;
  assign pos_x = px;
  assign pos_y = py;
  assign tex_u = u_d[PIPE_LAT-DIV_STAGES-1];
  assign tex_v = v_d[PIPE_LAT-DIV_STAGES-1];

  // a request shows up as corner 0 after the full latency
  `ASSERT_PROP(a_latency, clk, rst, accept |-> ##8 (strobe && corner == 2'd0), "corner 0 late")
  // vertices of a sprite leave back to back
  `ASSERT_PROP(a_burst, clk, rst, (strobe && !last) |=> strobe, "gap inside a quad")
  // last marks the final corner only
  `ASSERT_ALWAYS(a_last, clk, rst, !strobe || (last == (corner == CORNER_LAST)), "bad last")
endmodule
